### sv/gts_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the saturating arithmetic helper of the thermostat step block.
package gts_pkg;

    localparam int VAL_W     = 32;
    localparam int SCALE_W   = 31;
    localparam int NOISE_IN  = 4;
    localparam int MAT_STORE = 16;
    localparam int MIDX_W    = 7;
    localparam int DIV_W     = 48;
    localparam int ACC_W     = 72;

    typedef enum logic [1:0] {
        REQ_DRIFT = 2'd0,
        REQ_NOISE = 2'd1,
        REQ_PROP  = 2'd2,
        REQ_NONE  = 2'd3
    } t_req;

    typedef enum logic [4:0] {
        S_CLR, S_IDLE, S_P0M, S_P0, S_RD, S_RDW, S_MAC, S_ROW, S_DIV, S_DIVF,
        S_PNM, S_PN, S_SQ1, S_SQ2, S_E, S_EH, S_EL, S_DE, S_DONE
    } t_state;

    function automatic logic signed [VAL_W-1:0] sat32(input logic signed [79:0] x);
        logic signed [79:0] hi;
        logic signed [79:0] lo;
        hi = 80'sh7FFF_FFFF;
        lo = -80'sh8000_0000;
        if (x > hi) begin
            sat32 = 32'sh7FFF_FFFF;
        end else if (x < lo) begin
            sat32 = 32'sh8000_0000;
        end else begin
            sat32 = x[VAL_W-1:0];
        end
    endfunction

endpackage

### sv/gts_req_if.sv
`timescale 1ns / 1ps
// Input item channel of the thermostat step block.
interface gts_req_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    req_type;
    logic [9:0]                    atom_index;
    logic [1:0]                    axis;
    logic [3:0]                    entry_index;
    logic signed [31:0]            load_value;
    logic                          in_group;
    logic signed [31:0]            velocity;
    logic [30:0]                   sqrt_mass;
    logic signed [31:0]            noise_0;
    logic signed [31:0]            noise_1;
    logic signed [31:0]            noise_2;
    logic signed [31:0]            noise_3;

    modport source (output valid, req_type, atom_index, axis, entry_index, load_value,
                    in_group, velocity, sqrt_mass, noise_0, noise_1, noise_2, noise_3,
                    input ready);
    modport sink (input valid, req_type, atom_index, axis, entry_index, load_value,
                  in_group, velocity, sqrt_mass, noise_0, noise_1, noise_2, noise_3,
                  output ready);
endinterface

### sv/gts_res_if.sv
`timescale 1ns / 1ps
// Result channel of the thermostat step block.
interface gts_res_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] new_velocity;
    logic signed [31:0] energy_change;
    logic signed [63:0] energy_total;

    modport source (output valid, new_velocity, energy_change, energy_total, input ready);
    modport sink (input valid, new_velocity, energy_change, energy_total, output ready);
endinterface

### sv/gle_thermostat_velocity_step.sv
`timescale 1ns / 1ps
// Top level: one thermostat step per transfer, auxiliary momenta held in a memory with
// one read and one write port. Loads and pass-through items go from idle to the done
// state and then to the result register. A propagate's length is set by the one shared
// multiplier, the registered memory read and the bit-serial 48-step divider.
// One item is worked on at a time; the next is taken while the previous result waits.
// After reset a clearing pass over all 3*MAX_ATOMS*AUX_COUNT words zeroes the memory first.
module gle_thermostat_velocity_step #(
    parameter int AUX_COUNT = 3,
    parameter int MAX_ATOMS = 1024
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [gts_pkg::SCALE_W-1:0]  i_cfg_wdata,
    gts_req_if.sink                      i_req,
    gts_res_if.source                    o_res
);
    import gts_pkg::*;

    localparam int DIM   = AUX_COUNT + 1;
    localparam int MSIZE = DIM * DIM;
    localparam int DEPTH = MAX_ATOMS * 3 * AUX_COUNT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int JW    = (AUX_COUNT > 1) ? $clog2(AUX_COUNT) : 1;
    localparam int RW    = $clog2(DIM);
    localparam int KW    = $clog2(2 * DIM);

    t_state                    r_state, n_state;
    logic [SCALE_W-1:0]        r_scale;
    logic signed [VAL_W-1:0]   r_drift [MAT_STORE];
    logic signed [VAL_W-1:0]   r_noise [MAT_STORE];
    logic signed [63:0]        r_etot;
    logic [AW-1:0]             r_clr;
    logic                      r_ovld;

    logic signed [VAL_W-1:0]   mem_aux [DEPTH];
    logic signed [VAL_W-1:0]   r_rdata;

    logic [AW-1:0]             r_base;
    logic signed [VAL_W-1:0]   r_vel;
    logic [SCALE_W-1:0]        r_sm;
    logic signed [VAL_W-1:0]   r_xi [NOISE_IN];
    logic signed [VAL_W-1:0]   r_p [DIM];
    logic [RW-1:0]             r_row;
    logic [KW-1:0]             r_k;
    logic                      r_pv;
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [VAL_W-1:0]   r_np0;
    logic [JW-1:0]             r_j;
    logic [DIV_W-1:0]          r_dvd;
    logic [DIV_W-1:0]          r_q;
    logic [VAL_W-1:0]          r_rem;
    logic [5:0]                r_dcnt;
    logic signed [VAL_W-1:0]   r_vout;
    logic signed [VAL_W-1:0]   r_pnew;
    logic signed [63:0]        r_d;
    logic signed [48:0]        r_e;
    logic signed [65:0]        r_ehp;
    logic signed [65:0]        r_prod;
    logic signed [VAL_W-1:0]   r_de;
    logic signed [VAL_W-1:0]   r_o_vel;
    logic signed [VAL_W-1:0]   r_o_de;
    logic signed [63:0]        r_o_tot;

    logic signed [32:0]        mul_a, mul_b;
    logic                      aux_re, aux_we;
    logic [AW-1:0]             aux_ra, aux_wa;
    logic signed [VAL_W-1:0]   aux_wd;
    logic                      acc_in, prop_ok, out_load;
    logic [RW-1:0]             k_idx;
    logic [MIDX_W-1:0]         m_idx;
    logic signed [VAL_W-1:0]   drift_sel, noise_sel, xi_sel;
    logic signed [ACC_W-1:0]   row_sum;
    logic signed [ACC_W-1:0]   row_rnd;
    logic signed [VAL_W-1:0]   npv;
    logic signed [65:0]        rnd_prod;
    logic [VAL_W-1:0]          rem_sh;
    logic                      rem_ge;
    logic [VAL_W-1:0]          np0_mag;
    logic signed [65:0]        d_sum;
    logic signed [65:0]        e_rnd;
    logic signed [65:0]        lo_rnd;
    logic signed [VAL_W-1:0]   de_val;
    logic signed [64:0]        tot_sum;

    assign acc_in   = i_req.valid && i_req.ready;
    assign prop_ok  = (t_req'(i_req.req_type) == REQ_PROP) && i_req.in_group
                      && (i_req.axis != 2'd3) && (int'(i_req.atom_index) < MAX_ATOMS);
    assign out_load = (r_state == S_DONE) && (!r_ovld || o_res.ready);

    assign k_idx     = r_k[KW-1:1];
    assign m_idx     = MIDX_W'(r_row) * MIDX_W'(DIM) + MIDX_W'(k_idx);
    assign drift_sel = (m_idx < MIDX_W'(MAT_STORE)) ? r_drift[m_idx[3:0]] : '0;
    assign noise_sel = (m_idx < MIDX_W'(MAT_STORE)) ? r_noise[m_idx[3:0]] : '0;

    always_comb begin
        xi_sel = '0;
        for (int l = 0; l < NOISE_IN; l++) begin
            if (int'(k_idx) == l) begin
                xi_sel = r_xi[l];
            end
        end
    end

    assign row_sum  = r_acc + ACC_W'(r_prod);
    assign row_rnd  = (row_sum + ACC_W'(32768)) >>> 16;
    assign npv      = sat32(80'(row_rnd));
    assign rnd_prod = (r_prod + 66'sd32768) >>> 16;
    assign rem_sh   = {r_rem[VAL_W-2:0], r_dvd[DIV_W-1]};
    assign rem_ge   = rem_sh >= {1'b0, r_sm};
    assign np0_mag  = r_np0[VAL_W-1] ? (32'd0 - r_np0) : r_np0;
    assign d_sum    = 66'(r_d) - r_prod;
    assign e_rnd    = (d_sum + 66'sd65536) >>> 17;
    assign lo_rnd   = (r_prod + 66'sd32768) >>> 16;
    assign de_val   = sat32(80'(r_ehp + lo_rnd));
    assign tot_sum  = 65'(r_etot) + 65'(de_val);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLR:  if (r_clr == AW'(DEPTH - 1)) n_state = S_IDLE;
            S_IDLE: if (acc_in) n_state = prop_ok ? S_P0M : S_DONE;
            S_P0M:  n_state = S_P0;
            S_P0:   n_state = S_RD;
            S_RD:   n_state = S_RDW;
            S_RDW:  n_state = (r_j == JW'(AUX_COUNT - 1)) ? S_MAC : S_RD;
            S_MAC:  if (r_k == KW'(2 * DIM - 1)) n_state = S_ROW;
            S_ROW:  n_state = (r_row == RW'(DIM - 1)) ? S_DIV : S_MAC;
            S_DIV:  if (r_dcnt == 6'(DIV_W - 1)) n_state = S_DIVF;
            S_DIVF: n_state = S_PNM;
            S_PNM:  n_state = S_PN;
            S_PN:   n_state = S_SQ1;
            S_SQ1:  n_state = S_SQ2;
            S_SQ2:  n_state = S_E;
            S_E:    n_state = S_EH;
            S_EH:   n_state = S_EL;
            S_EL:   n_state = S_DE;
            S_DE:   n_state = S_DONE;
            S_DONE: if (out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        i_req.ready = (r_state == S_IDLE);
        mul_a  = '0;
        mul_b  = '0;
        aux_re = 1'b0;
        aux_ra = r_base + AW'(r_j);
        aux_we = 1'b0;
        aux_wa = r_clr;
        aux_wd = '0;
        unique case (r_state)
            S_CLR: aux_we = 1'b1;
            S_P0M: begin
                mul_a = 33'(r_vel);
                mul_b = {2'b00, r_sm};
            end
            S_RD: aux_re = 1'b1;
            S_MAC: begin
                mul_a = r_k[0] ? 33'(noise_sel) : 33'(drift_sel);
                mul_b = r_k[0] ? 33'(xi_sel) : 33'(r_p[k_idx]);
            end
            S_ROW: begin
                aux_we = (r_row != '0);
                aux_wa = r_base + AW'(r_row) - AW'(1);
                aux_wd = npv;
            end
            S_PNM: begin
                mul_a = 33'(r_vout);
                mul_b = {2'b00, r_sm};
            end
            S_SQ1: begin
                mul_a = 33'(r_pnew);
                mul_b = 33'(r_pnew);
            end
            S_SQ2: begin
                mul_a = 33'(r_p[0]);
                mul_b = 33'(r_p[0]);
            end
            S_EH: begin
                mul_a = $signed(r_e[48:16]);
                mul_b = {2'b00, r_scale};
            end
            S_EL: begin
                mul_a = {17'd0, r_e[15:0]};
                mul_b = {2'b00, r_scale};
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (aux_we) begin
            mem_aux[aux_wa] <= aux_wd;
        end
        if (aux_re) begin
            r_rdata <= mem_aux[aux_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= SCALE_W'(65536);
            r_etot  <= '0;
            r_clr   <= '0;
            r_ovld  <= 1'b0;
            for (int m = 0; m < MAT_STORE; m++) begin
                r_drift[m] <= '0;
                r_noise[m] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_scale <= i_cfg_wdata;
            end
            if (r_state == S_CLR) begin
                r_clr <= r_clr + AW'(1);
            end
            if (acc_in && (int'(i_req.entry_index) < MSIZE)) begin
                if (t_req'(i_req.req_type) == REQ_DRIFT) begin
                    r_drift[i_req.entry_index] <= i_req.load_value;
                end else if (t_req'(i_req.req_type) == REQ_NOISE) begin
                    r_noise[i_req.entry_index] <= i_req.load_value;
                end
            end
            if (r_state == S_DE) begin
                if (tot_sum[64] != tot_sum[63]) begin
                    r_etot <= tot_sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
                end else begin
                    r_etot <= tot_sum[63:0];
                end
            end
            if (out_load) begin
                r_ovld <= 1'b1;
            end else if (o_res.ready) begin
                r_ovld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        unique case (r_state)
            S_IDLE: begin
                r_vel  <= i_req.velocity;
                r_sm   <= (i_req.sqrt_mass == '0) ? SCALE_W'(1) : i_req.sqrt_mass;
                r_xi[0] <= i_req.noise_0;
                r_xi[1] <= i_req.noise_1;
                r_xi[2] <= i_req.noise_2;
                r_xi[3] <= i_req.noise_3;
                r_base <= AW'((int'(i_req.atom_index) * 3 + int'(i_req.axis)) * AUX_COUNT);
                r_vout <= (t_req'(i_req.req_type) == REQ_PROP) ? i_req.velocity : '0;
                r_de   <= '0;
                r_j    <= '0;
                r_row  <= '0;
                r_k    <= '0;
                r_pv   <= 1'b0;
            end
            S_P0: r_p[0] <= sat32(80'(rnd_prod));
            S_RDW: begin
                for (int l = 1; l < DIM; l++) begin
                    if (l == int'(r_j) + 1) begin
                        r_p[l] <= r_rdata;
                    end
                end
                r_j <= r_j + JW'(1);
            end
            S_MAC: begin
                r_acc <= r_pv ? (r_acc + ACC_W'(r_prod)) : '0;
                r_pv  <= 1'b1;
                r_k   <= r_k + KW'(1);
            end
            S_ROW: begin
                r_row <= r_row + RW'(1);
                r_k   <= '0;
                r_pv  <= 1'b0;
                if (r_row == '0) begin
                    r_np0 <= npv;
                end
                r_dvd  <= {np0_mag, 16'd0} + DIV_W'(r_sm >> 1);
                r_rem  <= '0;
                r_q    <= '0;
                r_dcnt <= '0;
            end
            S_DIV: begin
                r_rem  <= rem_ge ? (rem_sh - {1'b0, r_sm}) : rem_sh;
                r_dvd  <= {r_dvd[DIV_W-2:0], 1'b0};
                r_q    <= {r_q[DIV_W-2:0], rem_ge};
                r_dcnt <= r_dcnt + 6'd1;
            end
            S_DIVF: begin
                if (!r_np0[VAL_W-1]) begin
                    r_vout <= (|r_q[DIV_W-1:31]) ? 32'sh7FFF_FFFF : r_q[31:0];
                end else begin
                    r_vout <= (r_q > DIV_W'(33'h1_0000_0000 >> 1)) ? 32'sh8000_0000
                                                                : (32'd0 - r_q[31:0]);
                end
            end
            S_PN:  r_pnew <= sat32(80'(rnd_prod));
            S_SQ2: r_d <= r_prod[63:0];
            S_E:   r_e <= e_rnd[48:0];
            S_EL:  r_ehp <= r_prod;
            S_DE:  r_de <= de_val;
            default: ;
        endcase
        if (out_load) begin
            r_o_vel <= r_vout;
            r_o_de  <= r_de;
            r_o_tot <= r_etot;
        end
    end

    assign o_res.valid         = r_ovld;
    assign o_res.new_velocity  = r_o_vel;
    assign o_res.energy_change = r_o_de;
    assign o_res.energy_total  = r_o_tot;

    a_no_take_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLR) |-> !i_req.ready)
        else $error("input taken during clearing pass");

    a_aux_write_place: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        aux_we |-> (r_state == S_CLR || r_state == S_ROW))
        else $error("auxiliary memory written outside clear or row finish");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc_in |=> (r_state != S_IDLE))
        else $error("transfer accepted but sequencer stayed idle");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovld) |-> ($past(r_state) == S_DONE))
        else $error("result raised outside the done state");

endmodule

### tb/gts_checker.sv
`timescale 1ns / 1ps
// Watches both channels and the scale register, predicts every result and compares it.
module gts_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [30:0] i_cfg_wdata,
    gts_req_if          req,
    gts_res_if          res,
    output int          o_fail_count,
    output int          o_pending
);
    import gts_pkg::*;

    typedef struct packed {
        logic signed [31:0] vel;
        logic signed [31:0] de;
        logic signed [63:0] tot;
    } t_step_result;

    typedef logic signed [31:0] t_vec [4];

    t_step_result       step_results_q[$];
    logic signed [31:0] drift_mat [16];
    logic signed [31:0] noise_mat [16];
    logic signed [31:0] aux_mom [9216];
    logic signed [63:0] energy_sum;
    logic [30:0]        unit_scale;

    initial begin
        foreach (drift_mat[i]) drift_mat[i] = '0;
        foreach (noise_mat[i]) noise_mat[i] = '0;
        foreach (aux_mom[i]) aux_mom[i] = '0;
        energy_sum   = '0;
        unit_scale   = 31'd65536;
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic logic signed [31:0] clamp32(input logic signed [63:0] x);
        if (x > 64'sh7FFF_FFFF) begin
            return 32'sh7FFF_FFFF;
        end
        if (x < -64'sh8000_0000) begin
            return 32'sh8000_0000;
        end
        return x[31:0];
    endfunction

    function automatic logic signed [31:0] mix_row(input int row, input t_vec p, input t_vec xi);
        logic signed [63:0] hi;
        logic [63:0]        lo;
        logic signed [63:0] a;
        logic signed [63:0] b;
        hi = '0;
        lo = '0;
        for (int k = 0; k < 4; k++) begin
            a = drift_mat[row*4+k] * p[k];
            b = noise_mat[row*4+k] * xi[k];
            hi += (a >>> 16) + (b >>> 16);
            lo += {48'b0, a[15:0]} + {48'b0, b[15:0]};
        end
        return clamp32(hi + $signed((lo + 64'h8000) >> 16));
    endfunction

    function automatic logic signed [31:0] mass_scale(input logic signed [31:0] v,
                                                       input logic signed [63:0] sm);
        logic signed [63:0] x;
        x = v * sm;
        return clamp32((x + 64'sd32768) >>> 16);
    endfunction

    function automatic t_step_result thermostat_step();
        t_step_result       r;
        t_vec               p;
        t_vec               xi;
        t_vec               np;
        int                 base;
        logic signed [63:0] sm;
        logic signed [63:0] sc;
        logic signed [63:0] num;
        logic [63:0]        mag;
        logic [63:0]        q;
        logic signed [31:0] pnew;
        logic signed [63:0] d;
        logic signed [63:0] e;
        logic signed [63:0] el;
        logic signed [64:0] s;
        r.vel = '0;
        r.de  = '0;
        case (t_req'(req.req_type))
            REQ_DRIFT: drift_mat[req.entry_index] = req.load_value;
            REQ_NOISE: noise_mat[req.entry_index] = req.load_value;
            REQ_PROP: begin
                r.vel = req.velocity;
                if (req.in_group && req.axis != 2'd3) begin
                    base = (int'(req.atom_index) * 3 + int'(req.axis)) * 3;
                    sm = {33'b0, req.sqrt_mass};
                    if (sm == 0) sm = 1;
                    p[0] = mass_scale(req.velocity, sm);
                    for (int j = 1; j < 4; j++) p[j] = aux_mom[base+j-1];
                    xi[0] = req.noise_0;
                    xi[1] = req.noise_1;
                    xi[2] = req.noise_2;
                    xi[3] = req.noise_3;
                    for (int j = 0; j < 4; j++) np[j] = mix_row(j, p, xi);
                    for (int j = 1; j < 4; j++) aux_mom[base+j-1] = np[j];
                    num = np[0] * 64'sd65536;
                    mag = (num < 0) ? -num : num;
                    q = (mag + sm / 2) / sm;
                    r.vel = clamp32((num < 0) ? -$signed(q) : $signed(q));
                    pnew = mass_scale(r.vel, sm);
                    d = pnew * pnew - p[0] * p[0];
                    e = (d + 64'sd65536) >>> 17;
                    el = {48'b0, e[15:0]};
                    sc = {33'b0, unit_scale};
                    r.de = clamp32((e >>> 16) * sc + ((el * sc + 64'sd32768) >>> 16));
                    s = energy_sum + r.de;
                    if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) begin
                        energy_sum = 64'sh7FFF_FFFF_FFFF_FFFF;
                    end else if (s < -65'sh0_8000_0000_0000_0000) begin
                        energy_sum = 64'sh8000_0000_0000_0000;
                    end else begin
                        energy_sum = s[63:0];
                    end
                end
            end
            default: ;
        endcase
        r.tot = energy_sum;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_step_result want;
        if (i_rst_n) begin
            if (i_cfg_we) begin
                unit_scale = i_cfg_wdata;
            end
            if (req.valid && req.ready) begin
                step_results_q.push_back(thermostat_step());
            end
            if (res.valid && res.ready) begin
                if (step_results_q.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10) begin
                        $display("%0t: result with nothing expected: vel %0d de %0d tot %0d",
                                 $realtime, res.new_velocity, res.energy_change,
                                 res.energy_total);
                    end
                end else begin
                    want = step_results_q.pop_front();
                    if (want.vel !== res.new_velocity || want.de !== res.energy_change ||
                        want.tot !== res.energy_total) begin
                        o_fail_count++;
                        if (o_fail_count <= 10) begin
                            $display("%0t: mismatch vel exp %0d got %0d, de exp %0d got %0d, %s",
                                     $realtime, want.vel, res.new_velocity, want.de,
                                     res.energy_change, "total follows");
                            $display("    tot exp %0d got %0d", want.tot, res.energy_total);
                        end
                    end
                end
            end
            o_pending = step_results_q.size();
        end
    end
endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// Stimulus, reset, clock and verdict for the thermostat step block.
module tb;
    import gts_pkg::*;

    localparam int STALL_LIMIT = 40000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [30:0] i_cfg_wdata;
    int          fail_count;
    int          pending;
    int          idle_mode;
    int          quiet_cycles;

    gts_req_if req_if ();
    gts_res_if res_if ();

    gle_thermostat_velocity_step dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_if),
        .o_res       (res_if)
    );

    gts_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .req          (req_if),
        .res          (res_if),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // The receiver stalls on its own schedule, set by the current idling mode.
    always @(negedge i_clk) begin
        if (idle_mode == 2) begin
            res_if.ready = ($urandom_range(99) >= 57);
        end else if (idle_mode == 3) begin
            res_if.ready = ($urandom_range(99) >= 19);
        end else begin
            res_if.ready = 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("gle_thermostat_velocity_step verification failed");
            $finish;
        end
    end

    task automatic send(input t_req rt, input logic [9:0] atom, input logic [1:0] ax,
                        input logic [3:0] entry, input logic signed [31:0] lv,
                        input logic grp, input logic signed [31:0] vel,
                        input logic [30:0] sm, input logic signed [31:0] n0,
                        input logic signed [31:0] n1, input logic signed [31:0] n2,
                        input logic signed [31:0] n3);
        if (idle_mode == 1) begin
            while ($urandom_range(99) < 57) begin
                req_if.valid = 1'b0;
                @(negedge i_clk);
            end
        end else if (idle_mode == 3) begin
            while ($urandom_range(99) < 19) begin
                req_if.valid = 1'b0;
                @(negedge i_clk);
            end
        end
        req_if.req_type    = rt;
        req_if.atom_index  = atom;
        req_if.axis        = ax;
        req_if.entry_index = entry;
        req_if.load_value  = lv;
        req_if.in_group    = grp;
        req_if.velocity    = vel;
        req_if.sqrt_mass   = sm;
        req_if.noise_0     = n0;
        req_if.noise_1     = n1;
        req_if.noise_2     = n2;
        req_if.noise_3     = n3;
        req_if.valid       = 1'b1;
        do @(posedge i_clk); while (!req_if.ready);
        @(negedge i_clk);
    endtask

    task automatic load_entry(input t_req rt, input int entry, input logic signed [31:0] v);
        send(rt, 10'($urandom), 2'($urandom), 4'(entry), v, 1'($urandom), $urandom,
             31'($urandom), $urandom, $urandom, $urandom, $urandom);
    endtask

    task automatic propagate(input logic [9:0] atom, input logic [1:0] ax, input logic grp,
                             input logic signed [31:0] vel, input logic [30:0] sm,
                             input logic signed [31:0] n0, input logic signed [31:0] n1,
                             input logic signed [31:0] n2, input logic signed [31:0] n3);
        send(REQ_PROP, atom, ax, 4'($urandom), $urandom, grp, vel, sm, n0, n1, n2, n3);
    endtask

    task automatic drain_and_configure(input logic [30:0] scale);
        req_if.valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = scale;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
    endtask

    function automatic logic signed [31:0] small_val(input int span);
        return int'($urandom_range(2 * span)) - span;
    endfunction

    task automatic program_matrices(input bit wild);
        logic signed [31:0] v;
        for (int i = 0; i < 16; i++) begin
            if (wild) v = $urandom;
            else if (i % 5 == 0) v = 32'sd58000 + int'($urandom_range(6000));
            else v = small_val(3000);
            load_entry(REQ_DRIFT, i, v);
        end
        for (int i = 0; i < 16; i++) begin
            v = wild ? $urandom : small_val(9000);
            load_entry(REQ_NOISE, i, v);
        end
    endtask

    task automatic random_propagate();
        logic [9:0]         atom;
        logic [30:0]        sm;
        logic signed [31:0] vel;
        logic signed [31:0] n [4];
        atom = ($urandom_range(3) == 0) ? 10'($urandom) : 10'($urandom_range(7));
        case ($urandom_range(9))
            0:       sm = 31'($urandom);
            1:       sm = 31'($urandom_range(1));
            2:       sm = 31'h7FFF_FFFF;
            default: sm = 31'($urandom_range(32'h0010_0000, 32'h0000_8000));
        endcase
        vel = ($urandom_range(7) == 0) ? $urandom : small_val(32'h0004_0000);
        foreach (n[k]) n[k] = ($urandom_range(7) == 0) ? $urandom : small_val(32'h0002_0000);
        propagate(atom, ($urandom_range(15) == 0) ? 2'd3 : 2'($urandom_range(2)),
                  ($urandom_range(9) != 0), vel, sm, n[0], n[1], n[2], n[3]);
    endtask

    initial begin
        logic [30:0] scales [4];
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        idle_mode = 0;
        quiet_cycles = 0;
        res_if.ready = 1'b0;
        req_if.valid = 1'b0;
        req_if.req_type = REQ_DRIFT;
        req_if.atom_index = '0;
        req_if.axis = '0;
        req_if.entry_index = '0;
        req_if.load_value = '0;
        req_if.in_group = 1'b0;
        req_if.velocity = '0;
        req_if.sqrt_mass = '0;
        req_if.noise_0 = '0;
        req_if.noise_1 = '0;
        req_if.noise_2 = '0;
        req_if.noise_3 = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        drain_and_configure(31'd65536);

        // Directed part: extreme loads, extreme velocities and masses, and the bypass cases.
        load_entry(REQ_DRIFT, 0, 32'sh7FFF_FFFF);
        load_entry(REQ_DRIFT, 5, 32'sd65536);
        load_entry(REQ_DRIFT, 15, 32'sh8000_0000);
        load_entry(REQ_NOISE, 0, 32'sh8000_0000);
        load_entry(REQ_NOISE, 10, 32'sh7FFF_FFFF);
        load_entry(REQ_DRIFT, 4, 32'sd30000);
        propagate(10'd0, 2'd0, 1'b1, 32'sh7FFF_FFFF, 31'h7FFF_FFFF, 32'sh7FFF_FFFF,
                  32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000);
        propagate(10'd0, 2'd0, 1'b1, 32'sh8000_0000, 31'd0, 32'sd65536, 0, 0, 0);
        propagate(10'd1023, 2'd2, 1'b1, 32'sd65536, 31'd1, 32'sh8000_0000, 32'sd70000,
                  32'sd1, 32'sh7FFF_FFFF);
        propagate(10'd1023, 2'd2, 1'b1, -32'sd65536, 31'd65536, 0, 0, 0, 0);
        propagate(10'd5, 2'd3, 1'b1, 32'sd12345, 31'd65536, 1, 2, 3, 4);
        propagate(10'd5, 2'd1, 1'b0, -32'sd777, 31'd65536, 1, 2, 3, 4);
        send(REQ_NONE, 10'd3, 2'd1, 4'd7, 32'sd99, 1'b1, 32'sd5, 31'd9, 1, 2, 3, 4);
        load_entry(REQ_DRIFT, 0, 32'sd65536);
        load_entry(REQ_DRIFT, 15, 32'sd65536);
        load_entry(REQ_NOISE, 0, 32'sd6000);
        load_entry(REQ_NOISE, 10, 0);
        propagate(10'd1023, 2'd2, 1'b1, 32'sd100000, 31'd131072, 32'sd65536,
                  -32'sd65536, 32'sd1000, 0);
        propagate(10'd0, 2'd0, 1'b1, 0, 31'h7FFF_FFFF, 0, 0, 0, 0);

        scales[0] = 31'd1;
        scales[1] = 31'h7FFF_FFFF;
        scales[2] = 31'd65536;
        scales[3] = 31'($urandom);
        for (int ph = 0; ph < 4; ph++) begin
            drain_and_configure(scales[ph]);
            idle_mode = ph;
            program_matrices(1'b0);
            for (int i = 0; i < 330; i++) begin
                if ($urandom_range(9) == 0) begin
                    send(t_req'($urandom_range(3)), 10'($urandom), 2'($urandom),
                         4'($urandom), $urandom, 1'($urandom), $urandom, 31'($urandom),
                         $urandom, $urandom, $urandom, $urandom);
                end else begin
                    random_propagate();
                end
                if (i == 165) program_matrices(($urandom_range(3) == 0));
            end
        end

        req_if.valid = 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (150) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("gle_thermostat_velocity_step verification clean");
        end else begin
            $display("gle_thermostat_velocity_step verification failed");
        end
        $finish;
    end
endmodule

### sim.f
sv/gts_pkg.sv
sv/gts_req_if.sv
sv/gts_res_if.sv
sv/gle_thermostat_velocity_step.sv
tb/gts_checker.sv
tb/tb.sv
